/* hdl/ookt_pkg.sv */
// ookt_pkg: shared types and constants for the ook pulse frame transmitter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ookt_pkg;

    localparam int FRAME_BYTES  = 7;
    localparam int FRAME_BITS   = FRAME_BYTES * 8;
    localparam int SYNC_PULSES_DEF = 8;
    localparam int WIDTH_BITS   = 16;
    localparam int PADDR_BITS   = 5;
    localparam int PDATA_BITS   = 32;

    localparam logic [WIDTH_BITS-1:0] SHORT_BIT_RST  = 16'd210;
    localparam logic [WIDTH_BITS-1:0] LONG_BIT_RST   = 16'd401;
    localparam logic [WIDTH_BITS-1:0] PRE_SYNC_RST   = 16'd207;
    localparam logic [WIDTH_BITS-1:0] LONG_SYNC_RST  = 16'd2205;
    localparam logic [WIDTH_BITS-1:0] SHORT_SYNC_RST = 16'd606;

    // register indexes on the apb port
    localparam logic [2:0] REG_SHORT_BIT  = 3'd0;
    localparam logic [2:0] REG_LONG_BIT   = 3'd1;
    localparam logic [2:0] REG_PRE_SYNC   = 3'd2;
    localparam logic [2:0] REG_LONG_SYNC  = 3'd3;
    localparam logic [2:0] REG_SHORT_SYNC = 3'd4;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_HEAD = 3'd2,
        PH_DATA = 3'd3,
        PH_TAIL = 3'd4
    } t_phase;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] short_bit;
        logic [WIDTH_BITS-1:0] long_bit;
        logic [WIDTH_BITS-1:0] pre_sync;
        logic [WIDTH_BITS-1:0] long_sync;
        logic [WIDTH_BITS-1:0] short_sync;
    } t_widths;

    // classified item as it travels from front to back
    typedef struct packed {
        logic                  op;
        logic                  with_pre;
        logic [FRAME_BITS-1:0] frame;
    } t_cmd;

    function automatic logic [7:0] even_par7(input logic [6:0] v);
        even_par7 = {^v, v};
    endfunction

endpackage

/* hdl/ookt_front.sv */
// ookt_front: accepts input items, classifies them and builds the 7-byte frame
// depends on ookt_pkg; feeds ookt_queue
`timescale 1ns / 1ps

module ookt_front import ookt_pkg::*; (
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [1:0]  i_channel,
    input  logic [6:0]  i_humidity,
    input  logic [13:0] i_temperature,
    input  logic        i_with_preamble,
    input  logic        i_push_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [7:0] b0, b3, b4, b5, b6;

    always_comb begin
        b0 = {i_channel, 6'b0};
        b3 = even_par7(i_humidity);
        b4 = even_par7(i_temperature[13:7]);
        b5 = even_par7(i_temperature[6:0]);
        // id bytes are zero so they drop out of the checksum
        b6 = b0 + b3 + b4 + b5;
    end

    always_comb begin
        o_cmd.op       = i_op;
        o_cmd.with_pre = i_with_preamble;
        // ticks carry no frame; zero keeps the queue contents quiet
        o_cmd.frame    = (i_op == OP_START) ? {b0, 8'h00, 8'h00, b3, b4, b5, b6}
                                            : '0;
    end

    assign o_in_stall = !i_push_ready;
    assign o_push     = i_in_valid && i_push_ready;

endmodule

/* hdl/ookt_queue.sv */
// ookt_queue: two-entry queue of classified items between front and back
// depends on ookt_pkg
`timescale 1ns / 1ps

module ookt_queue import ookt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_cmd        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/ookt_back.sv */
// ookt_back: pulse sequencer that carries out ticks and starts, plus result register
// depends on ookt_pkg; takes items from ookt_queue
`timescale 1ns / 1ps

module ookt_back import ookt_pkg::*; #(
    parameter int SYNC_PULSES = SYNC_PULSES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_widths i_widths,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output logic    o_line_level,
    output logic    o_edge_res,
    output logic    o_busy_res,
    output logic    o_frame_done
);

    localparam logic [6:0] SYNC_LAST = 7'(SYNC_PULSES + 2);
    localparam logic [6:0] DATA_LAST = 7'(FRAME_BITS * 2);

    t_phase                r_phase, n_phase;
    logic                  r_level, n_level;
    logic                  r_busy, n_busy;
    logic [6:0]            r_pidx, n_pidx;
    logic [WIDTH_BITS-1:0] r_elapsed, n_elapsed;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic                  r_out_valid;
    logic                  r_edge, n_edge;
    logic                  r_done, n_done;

    logic [WIDTH_BITS-1:0] cur_width, sync_w, elapsed_inc;
    logic [6:0]            pidx_inc;
    logic                  cur_bit;

    assign o_pop        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_level;
    assign o_busy_res   = r_busy;
    assign o_edge_res   = r_edge;
    assign o_frame_done = r_done;

    always_comb begin
        cur_bit = r_frame[FRAME_BITS-1];
        case (r_pidx)
            7'd0:    sync_w = i_widths.pre_sync;
            7'd1:    sync_w = i_widths.long_sync;
            default: sync_w = i_widths.short_sync;
        endcase
        case (r_phase)
            PH_PRE:  cur_width = (r_pidx == 7'd0) ? i_widths.short_bit : i_widths.long_bit;
            PH_HEAD,
            PH_TAIL: cur_width = sync_w;
            default: begin
                // data bit: 1 is long then short, 0 is short then long
                if (r_pidx[0] == cur_bit) begin
                    cur_width = i_widths.short_bit;
                end else begin
                    cur_width = i_widths.long_bit;
                end
            end
        endcase
        elapsed_inc = r_elapsed + 16'd1;
        pidx_inc    = r_pidx + 7'd1;
    end

    always_comb begin
        n_phase   = r_phase;
        n_level   = r_level;
        n_busy    = r_busy;
        n_pidx    = r_pidx;
        n_elapsed = r_elapsed;
        n_frame   = r_frame;
        n_edge    = 1'b0;
        n_done    = 1'b0;
        if (i_q_cmd.op == OP_START) begin
            if (!r_busy) begin
                n_frame   = i_q_cmd.frame;
                n_busy    = 1'b1;
                n_phase   = i_q_cmd.with_pre ? PH_PRE : PH_HEAD;
                n_pidx    = 7'd0;
                n_elapsed = '0;
            end
        end else if (r_busy) begin
            case (r_phase)
                PH_PRE, PH_HEAD, PH_DATA, PH_TAIL: begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= cur_width) begin
                        n_level   = !r_level;
                        n_edge    = 1'b1;
                        n_elapsed = '0;
                        n_pidx    = pidx_inc;
                        if (r_phase == PH_DATA && r_pidx[0]) begin
                            n_frame = {r_frame[FRAME_BITS-2:0], 1'b0};
                        end
                        if (r_phase == PH_PRE && pidx_inc == 7'd2) begin
                            n_phase = PH_HEAD;
                            n_pidx  = 7'd0;
                        end else if (r_phase == PH_HEAD && pidx_inc == SYNC_LAST) begin
                            n_phase = PH_DATA;
                            n_pidx  = 7'd0;
                        end else if (r_phase == PH_DATA && pidx_inc == DATA_LAST) begin
                            n_phase = PH_TAIL;
                            n_pidx  = 7'd0;
                        end else if (r_phase == PH_TAIL && pidx_inc == SYNC_LAST) begin
                            n_phase = PH_IDLE;
                            n_pidx  = 7'd0;
                            n_busy  = 1'b0;
                            n_done  = 1'b1;
                        end
                    end
                end
                default: begin
                    // idle or unused phase code while busy: drop back to idle
                    n_busy    = 1'b0;
                    n_phase   = PH_IDLE;
                    n_pidx    = 7'd0;
                    n_elapsed = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_level     <= 1'b1;
            r_busy      <= 1'b0;
            r_pidx      <= 7'd0;
            r_elapsed   <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
            r_edge      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_level   <= n_level;
                r_busy    <= n_busy;
                r_pidx    <= n_pidx;
                r_elapsed <= n_elapsed;
                r_frame   <= n_frame;
                r_edge    <= n_edge;
                r_done    <= n_done;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/ook_pulse_frame_transmitter_unit.sv */
// ook_pulse_frame_transmitter_unit: top level with apb width registers
// depends on ookt_pkg, ookt_front, ookt_queue, ookt_back
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_stall): one beat per item. op 0 is a one
// microsecond tick, op 1 starts a frame using channel, humidity, temperature
// and with_preamble. A start while a frame is in flight is ignored.
// Output channel (o_out_valid / i_out_stall): exactly one result beat per
// input beat, in order: line level, edge flag, busy flag, frame-done flag.
// Throughput is one item per cycle while the receiver does not stall; a
// result is registered after its input beat is taken (the beat lands in the
// queue, then passes the pulse sequencer into the result register). The
// two-entry queue lets input beats keep flowing while a result waits; when
// the receiver stalls, the queue fills and o_in_stall rises once both of
// its entries hold beats.
// Pulse widths are set over the apb port (5 registers, 16 bits each, at
// byte addresses 0,4,8,12,16); write them only while no frame is running.
// Reset (synchronous, active low) restores default widths, sets the line
// high, empties the queue and leaves the sequencer idle.

module ook_pulse_frame_transmitter_unit import ookt_pkg::*; #(
    parameter int SYNC_PULSES = SYNC_PULSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [1:0]            i_channel,
    input  logic [6:0]            i_humidity,
    input  logic [13:0]           i_temperature,
    input  logic                  i_with_preamble,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_line_level,
    output logic                  o_edge_res,
    output logic                  o_busy_res,
    output logic                  o_frame_done,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    t_widths    r_widths;
    logic       push, push_ready, q_valid, pop;
    t_cmd       f_cmd, q_cmd;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widths.short_bit  <= SHORT_BIT_RST;
            r_widths.long_bit   <= LONG_BIT_RST;
            r_widths.pre_sync   <= PRE_SYNC_RST;
            r_widths.long_sync  <= LONG_SYNC_RST;
            r_widths.short_sync <= SHORT_SYNC_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SHORT_BIT:  r_widths.short_bit  <= pwdata[WIDTH_BITS-1:0];
                REG_LONG_BIT:   r_widths.long_bit   <= pwdata[WIDTH_BITS-1:0];
                REG_PRE_SYNC:   r_widths.pre_sync   <= pwdata[WIDTH_BITS-1:0];
                REG_LONG_SYNC:  r_widths.long_sync  <= pwdata[WIDTH_BITS-1:0];
                REG_SHORT_SYNC: r_widths.short_sync <= pwdata[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SHORT_BIT:  prdata = {16'h0, r_widths.short_bit};
            REG_LONG_BIT:   prdata = {16'h0, r_widths.long_bit};
            REG_PRE_SYNC:   prdata = {16'h0, r_widths.pre_sync};
            REG_LONG_SYNC:  prdata = {16'h0, r_widths.long_sync};
            REG_SHORT_SYNC: prdata = {16'h0, r_widths.short_sync};
            default:        prdata = '0;
        endcase
    end

    ookt_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_humidity      (i_humidity),
        .i_temperature   (i_temperature),
        .i_with_preamble (i_with_preamble),
        .i_push_ready    (push_ready),
        .o_push          (push),
        .o_cmd           (f_cmd)
    );

    ookt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (f_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd)
    );

    ookt_back #(
        .SYNC_PULSES (SYNC_PULSES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_widths     (r_widths),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_level (o_line_level),
        .o_edge_res   (o_edge_res),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done)
    );

endmodule

/* tb/tb_ook_pulse_frame_transmitter_unit.sv */
// tb_ook_pulse_frame_transmitter_unit: self-checking bench for the ook pulse frame transmitter
// predicts line level, edge, busy and frame-done per item; needs ookt_pkg and the unit rtl only
`timescale 1ns / 1ps

module tb_ook_pulse_frame_transmitter_unit;
    import ookt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_PHASES = 2;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic level;
        logic toggled;
        logic busy;
        logic done;
    } t_line_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [1:0]            i_channel;
    logic [6:0]            i_humidity;
    logic [13:0]           i_temperature;
    logic                  i_with_preamble;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_line_level;
    logic                  o_edge_res;
    logic                  o_busy_res;
    logic                  o_frame_done;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    // transmitter shadow state
    logic                  tx_level;
    logic                  tx_busy;
    t_phase                tx_phase;
    logic [6:0]            tx_pidx;
    logic [15:0]           tx_elapsed;
    logic [FRAME_BITS-1:0] tx_frame;
    t_widths               width_cfg;

    t_line_res expected_line_q[$];

    int  error_count;
    int  beats_checked;
    int  frames_started;
    int  frames_done;
    int  in_stall_cycles;
    int  cycle_count;
    int  hold_request;
    bit  sender_gaps_on;
    bit  receiver_gaps_on;

    ook_pulse_frame_transmitter_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_humidity      (i_humidity),
        .i_temperature   (i_temperature),
        .i_with_preamble (i_with_preamble),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_level    (o_line_level),
        .o_edge_res      (o_edge_res),
        .o_busy_res      (o_busy_res),
        .o_frame_done    (o_frame_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
                     expected_line_q.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stall_cycles++;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [7:0] parity_byte(input logic [6:0] v);
        return {^v, v};
    endfunction

    function automatic logic [15:0] pulse_width();
        case (tx_phase)
            PH_PRE: return (tx_pidx == 7'd0) ? width_cfg.short_bit : width_cfg.long_bit;
            PH_HEAD, PH_TAIL: begin
                if (tx_pidx == 7'd0)
                    return width_cfg.pre_sync;
                if (tx_pidx == 7'd1)
                    return width_cfg.long_sync;
                return width_cfg.short_sync;
            end
            // data: first half long for a one, second half long for a zero
            default: return (tx_frame[FRAME_BITS-1] ^ tx_pidx[0]) ? width_cfg.long_bit
                                                                 : width_cfg.short_bit;
        endcase
    endfunction

    function automatic t_line_res step_transmitter(input logic op, input logic [1:0] ch,
            input logic [6:0] hum, input logic [13:0] temp, input logic pre);
        t_line_res res;
        logic [7:0] hum_b;
        logic [7:0] thi_b;
        logic [7:0] tlo_b;
        logic [7:0] sum_b;
        res = '0;
        if (op == OP_START) begin
            if (!tx_busy) begin
                hum_b = parity_byte(hum);
                thi_b = parity_byte(temp[13:7]);
                tlo_b = parity_byte(temp[6:0]);
                sum_b = {ch, 6'd0} + hum_b + thi_b + tlo_b;
                tx_frame   = {ch, 6'd0, 16'd0, hum_b, thi_b, tlo_b, sum_b};
                tx_busy    = 1'b1;
                tx_phase   = pre ? PH_PRE : PH_HEAD;
                tx_pidx    = '0;
                tx_elapsed = '0;
                frames_started++;
            end
        end else if (tx_busy) begin
            if (tx_phase == PH_IDLE) begin
                tx_busy    = 1'b0;
                tx_pidx    = '0;
                tx_elapsed = '0;
            end else begin
                tx_elapsed = tx_elapsed + 16'd1;
                if (tx_elapsed >= pulse_width()) begin
                    tx_level    = ~tx_level;
                    res.toggled = 1'b1;
                    tx_elapsed  = '0;
                    if (tx_phase == PH_DATA && tx_pidx[0])
                        tx_frame = tx_frame << 1;
                    tx_pidx = tx_pidx + 7'd1;
                    if (tx_phase == PH_PRE && tx_pidx == 7'd2) begin
                        tx_phase = PH_HEAD;
                        tx_pidx  = '0;
                    end else if (tx_phase == PH_HEAD && tx_pidx == SYNC_PULSES_DEF + 2) begin
                        tx_phase = PH_DATA;
                        tx_pidx  = '0;
                    end else if (tx_phase == PH_DATA && tx_pidx == FRAME_BITS * 2) begin
                        tx_phase = PH_TAIL;
                        tx_pidx  = '0;
                    end else if (tx_phase == PH_TAIL && tx_pidx == SYNC_PULSES_DEF + 2) begin
                        tx_phase = PH_IDLE;
                        tx_pidx  = '0;
                        tx_busy  = 1'b0;
                        res.done = 1'b1;
                    end
                end
            end
        end
        res.level = tx_level;
        res.busy  = tx_busy;
        return res;
    endfunction

    function automatic logic [15:0] width_of(input logic [2:0] idx);
        case (idx)
            REG_SHORT_BIT:  return width_cfg.short_bit;
            REG_LONG_BIT:   return width_cfg.long_bit;
            REG_PRE_SYNC:   return width_cfg.pre_sync;
            REG_LONG_SYNC:  return width_cfg.long_sync;
            default:        return width_cfg.short_sync;
        endcase
    endfunction

    function automatic void store_width(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            REG_SHORT_BIT:  width_cfg.short_bit  = val;
            REG_LONG_BIT:   width_cfg.long_bit   = val;
            REG_PRE_SYNC:   width_cfg.pre_sync   = val;
            REG_LONG_SYNC:  width_cfg.long_sync  = val;
            REG_SHORT_SYNC: width_cfg.short_sync = val;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_line_res exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_line_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                error_count++;
            end else begin
                exp_res = expected_line_q.pop_front();
                beats_checked++;
                if (o_line_level !== exp_res.level) begin
                    $error("line_level: expected %0d, actual %0d", exp_res.level, o_line_level);
                    error_count++;
                end
                if (o_edge_res !== exp_res.toggled) begin
                    $error("edge_res: expected %0d, actual %0d", exp_res.toggled, o_edge_res);
                    error_count++;
                end
                if (o_busy_res !== exp_res.busy) begin
                    $error("busy_res: expected %0d, actual %0d", exp_res.busy, o_busy_res);
                    error_count++;
                end
                if (o_frame_done !== exp_res.done) begin
                    $error("frame_done: expected %0d, actual %0d", exp_res.done, o_frame_done);
                    error_count++;
                end
                if (exp_res.done)
                    frames_done++;
            end
        end
    end

    // receiver: random stall bursts, plus a long hold when asked
    initial begin
        int burst_left;
        int hold_left;
        burst_left  = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                i_out_stall = 1'b1;
                burst_left--;
            end else if (receiver_gaps_on && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                burst_left  = $urandom_range(0, 14);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(input logic op, input logic [1:0] ch, input logic [6:0] hum,
            input logic [13:0] temp, input logic pre);
        t_line_res pred;
        if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_op            = op;
        i_channel       = ch;
        i_humidity      = hum;
        i_temperature   = temp;
        i_with_preamble = pre;
        do @(posedge i_clk); while (o_in_stall);
        pred = step_transmitter(op, ch, hum, temp, pre);
        expected_line_q.insert(expected_line_q.size(), pred);
        @(negedge i_clk);
    endtask

    // payload of a tick is ignored, so it carries noise
    task automatic send_tick();
        send_item(OP_TICK, 2'($urandom), 7'($urandom), 14'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_line_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic finish_frame();
        while (tx_busy)
            send_tick();
        wait_drained();
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [15:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = PDATA_BITS'(val);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            store_width(idx, val);
        end else if (prdata !== PDATA_BITS'(width_of(idx))) begin
            $error("prdata reg %0d: expected %0d, actual %0d", idx, width_of(idx), prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_widths(input logic [15:0] sb, input logic [15:0] lb,
            input logic [15:0] ps, input logic [15:0] ls, input logic [15:0] ss);
        apb_access(1'b1, REG_SHORT_BIT, sb);
        apb_access(1'b1, REG_LONG_BIT, lb);
        apb_access(1'b1, REG_PRE_SYNC, ps);
        apb_access(1'b1, REG_LONG_SYNC, ls);
        apb_access(1'b1, REG_SHORT_SYNC, ss);
    endtask

    task automatic read_all_widths();
        apb_access(1'b0, REG_SHORT_BIT, '0);
        apb_access(1'b0, REG_LONG_BIT, '0);
        apb_access(1'b0, REG_PRE_SYNC, '0);
        apb_access(1'b0, REG_LONG_SYNC, '0);
        apb_access(1'b0, REG_SHORT_SYNC, '0);
    endtask

    function automatic logic [15:0] rand_width();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(3, 8));
        return 16'($urandom_range(1, 2));
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_register_access();
        read_all_widths();
        set_widths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        read_all_widths();
        // idle ticks must not move the line whatever the widths
        repeat (4) send_tick();
        wait_drained();
        set_widths(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        read_all_widths();
    endtask

    task automatic test_directed_frames();
        set_widths(16'd1, 16'd2, 16'd1, 16'd2, 16'd1);
        repeat (3) send_tick();
        send_item(OP_START, 2'd3, 7'h7F, 14'h3FFF, 1'b1);
        // starts during a frame are dropped, right away and later on
        send_item(OP_START, 2'd0, 7'h00, 14'h0000, 1'b0);
        repeat (40) send_tick();
        send_item(OP_START, 2'd1, 7'h12, 14'h0155, 1'b1);
        finish_frame();
        // a zero width acts as one tick
        apb_access(1'b1, REG_SHORT_BIT, 16'd0);
        apb_access(1'b1, REG_SHORT_SYNC, 16'd0);
        send_item(OP_START, 2'd2, 7'd100, 14'd12345, 1'b0);
        finish_frame();
    endtask

    task automatic test_long_pulses();
        sender_gaps_on   = 1'b0;
        receiver_gaps_on = 1'b0;
        // short half wider than long half, and a wide sync pulse
        set_widths(16'd2, 16'd1, 16'd1, 16'd24, 16'd3);
        send_item(OP_START, 2'd1, 7'd50, 14'd8000, 1'b0);
        finish_frame();
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        set_widths(16'd1, 16'd2, 16'd1, 16'd2, 16'd1);
        hold_request = 80;
        send_item(OP_START, 2'd2, 7'd77, 14'd9001, 1'b1);
        repeat (60) send_tick();
        finish_frame();
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int  useful;
        bit  was_busy;
        logic op;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            finish_frame();
            if (ph == RANDOM_PHASES - 1) begin
                sender_gaps_on   = 1'b0;
                receiver_gaps_on = 1'b0;
            end
            set_widths(rand_width(), rand_width(), rand_width(), rand_width(), rand_width());
            apb_access(1'b0, 3'($urandom_range(0, 4)), '0);
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                was_busy = tx_busy;
                // mostly well-formed frames; stray starts land mid-frame
                if (was_busy)
                    op = ($urandom_range(0, 49) == 0) ? OP_START : OP_TICK;
                else
                    op = ($urandom_range(0, 3) == 0) ? OP_START : OP_TICK;
                send_item(op, 2'($urandom), 7'($urandom), 14'($urandom), 1'($urandom));
                if (was_busy ? (op == OP_TICK) : (op == OP_START))
                    useful++;
            end
        end
        finish_frame();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_op             = OP_TICK;
        i_channel        = '0;
        i_humidity       = '0;
        i_temperature    = '0;
        i_with_preamble  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        error_count      = 0;
        beats_checked    = 0;
        frames_started   = 0;
        frames_done      = 0;
        in_stall_cycles  = 0;
        cycle_count      = 0;
        hold_request     = 0;
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        tx_level         = 1'b1;
        tx_busy          = 1'b0;
        tx_phase         = PH_IDLE;
        tx_pidx          = '0;
        tx_elapsed       = '0;
        tx_frame         = '0;
        width_cfg        = '{SHORT_BIT_RST, LONG_BIT_RST, PRE_SYNC_RST, LONG_SYNC_RST,
                             SHORT_SYNC_RST};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        test_directed_frames();
        test_long_pulses();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        // any late beat now has nothing to match
        repeat (20) @(negedge i_clk);
        $display("run covered %0d frames started, %0d ended, %0d result beats checked",
                 frames_started, frames_done, beats_checked);
        $display("widths from 0 to 65535, input held off on %0d cycles", in_stall_cycles);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/ookt_pkg.sv
hdl/ookt_front.sv
hdl/ookt_queue.sv
hdl/ookt_back.sv
hdl/ook_pulse_frame_transmitter_unit.sv
tb/tb_ook_pulse_frame_transmitter_unit.sv
